>>> design/http_request_classifier_core_defines.svh
// Assertion macros shared by the request classifier RTL.
`ifndef HTTP_REQUEST_CLASSIFIER_CORE_DEFINES_SVH
`define HTTP_REQUEST_CLASSIFIER_CORE_DEFINES_SVH

// Property checked on every rising edge, skipped while reset is asserted.
`define HRC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define HRC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/hrc_pkg.sv
// Types, constants and prefix tables for the HTTP request classifier.
package hrc_pkg;

  localparam int MAX_HEADER_BYTES_DEF = 1024;
  localparam int NUM_PREFIXES         = 5;
  localparam int NUMBER_START         = 10;
  localparam int BYTE_W               = 8;
  localparam int LIMIT_W              = 16;
  localparam int NUM_W                = 16;
  localparam int BODY_W               = 11;
  localparam int ACC_W                = 17;
  localparam int OUTC_W               = 3;
  localparam int PAT_W                = 128;

  localparam logic [ACC_W-1:0]  ACC_MAX       = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd64;
  localparam logic [23:0]       CRLFCR        = 24'h0D0A0D;
  localparam logic [BYTE_W-1:0] CHAR_LF       = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE     = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_NUL      = 8'h00;

  typedef enum logic [OUTC_W-1:0] {
    OUT_STATUS    = 3'd0,
    OUT_CONFIGURE = 3'd1,
    OUT_RANK      = 3'd2,
    OUT_SIZE      = 3'd3,
    OUT_ROUTING   = 3'd4,
    OUT_NOT_FOUND = 3'd5,
    OUT_BAD       = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } num_phase_e;

  // Prefix strings, right aligned: the first character sits in the highest used byte.
  localparam logic [PAT_W-1:0] PAT_STR [NUM_PREFIXES] = '{
    PAT_W'("GET /status"),
    PAT_W'("POST /configure"),
    PAT_W'("PUT /rank/"),
    PAT_W'("PUT /size/"),
    PAT_W'("POST /routing")
  };
  localparam logic [3:0] PAT_LEN [NUM_PREFIXES] = '{4'd11, 4'd15, 4'd10, 4'd10, 4'd13};

  // Character of prefix idx at position p (p below the prefix length).
  function automatic logic [BYTE_W-1:0] pat_char(input logic [2:0] idx, input logic [3:0] p);
    logic [PAT_W-1:0] s;
    logic [3:0]       k;
    s = PAT_STR[idx];
    k = PAT_LEN[idx] - 4'd1 - p;
    return s[{k, 3'b000} +: BYTE_W];
  endfunction

endpackage

>>> design/http_request_classifier_core.sv
// Streaming HTTP request-line classifier: prefix match, number capture, header end.
//
//  channel | signals                                       | dir | word
//  --------+-----------------------------------------------+-----+----------------------------
//  in      | in_valid_i/in_ready_o, data_byte_i,           | in  | one request byte + flags
//          | first_byte_i, end_of_data_i                   |     |
//  out     | out_valid_o/out_ready_i, outcome_o,           | out | at most one result per request
//          | number_value_o, body_offset_o                 |     |
//  cfg     | cfg_we_i, cfg_wdata_i                         | in  | cluster limit, no wait
//
//  Cycles: one byte per cycle while in_ready_o is high. The request state updates at
//  the edge that takes the byte; a result is loaded into the output register at that
//  same edge and shows on out_valid_o in the next cycle.
//  Stalls: the output register holds one word; the input stays ready while it is empty
//  or being drained, so a byte is taken in the same cycle a waiting result leaves.
//  Reset: asynchronous, active low; clears control state and sets the limit to 64.
`include "http_request_classifier_core_defines.svh"

module http_request_classifier_core
  import hrc_pkg::*;
#(
  parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  // input bytes
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic               first_byte_i,
  input  logic               end_of_data_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OUTC_W-1:0]  outcome_o,
  output logic [NUM_W-1:0]   number_value_o,
  output logic [BODY_W-1:0]  body_offset_o
);

  localparam int CNT_W = $clog2(MAX_HEADER_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(NUMBER_START);

  // Request state
  logic [LIMIT_W-1:0]      limit_q;
  logic [NUM_PREFIXES-1:0] alive_q, alive_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [23:0]             recent_q, recent_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  num_phase_e              phase_q, phase_d;
  logic                    bad_q, bad_d;
  logic                    done_q, done_d;

  // Output register
  logic                    out_valid_q;
  outcome_e                outcome_q, outcome_d;
  logic [NUM_W-1:0]        number_q, number_d;
  logic [BODY_W-1:0]       offset_q, offset_d;
  logic                    res_fire;

  // Start-of-byte view, with the per-request clear applied on a first byte
  logic [NUM_PREFIXES-1:0] e_alive;
  logic [CNT_W-1:0]        e_cnt;
  logic [23:0]             e_recent;
  logic [ACC_W-1:0]        e_acc;
  num_phase_e              e_phase;
  logic                    e_bad;
  logic                    e_done;

  logic                    accept;
  logic [NUM_PREFIXES-1:0] kill;
  logic                    in_number;
  logic                    is_digit;
  logic [ACC_W+3:0]        acc_x10;
  logic                    hdr_end;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign e_alive  = first_byte_i ? '1 : alive_q;
  assign e_cnt    = first_byte_i ? '0 : cnt_q;
  assign e_recent = first_byte_i ? '0 : recent_q;
  assign e_acc    = first_byte_i ? '0 : acc_q;
  assign e_phase  = first_byte_i ? PH_BEFORE : phase_q;
  assign e_bad    = first_byte_i ? 1'b0 : bad_q;
  assign e_done   = first_byte_i ? 1'b0 : done_q;

  // Drop a prefix on the first mismatching character inside its length
  for (genvar i = 0; i < NUM_PREFIXES; i++) begin : g_match
    assign kill[i] = (e_cnt < CNT_W'(PAT_LEN[i]))
                  && (pat_char(3'(i), e_cnt[3:0]) != data_byte_i);
  end

  assign is_digit = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
  assign acc_x10  = {e_acc, 3'b000} + {3'b000, e_acc, 1'b0}
                  + (ACC_W+4)'(data_byte_i - CHAR_ZERO);
  assign hdr_end  = (e_recent == CRLFCR) && (data_byte_i == CHAR_LF);

  always_comb begin
    alive_d   = e_alive;
    cnt_d     = e_cnt;
    recent_d  = e_recent;
    acc_d     = e_acc;
    phase_d   = e_phase;
    bad_d     = e_bad;
    done_d    = e_done;
    res_fire  = 1'b0;
    outcome_d = OUT_BAD;
    number_d  = '0;
    offset_d  = '0;
    in_number = 1'b0;

    if (!e_done) begin
      if (data_byte_i == CHAR_NUL) begin
        // end of text: bad request, no body offset
        res_fire = 1'b1;
        done_d   = 1'b1;
      end else begin
        alive_d  = e_alive & ~kill;
        in_number = (e_cnt >= CNT_START) && (alive_d[OUT_RANK] || alive_d[OUT_SIZE])
                 && (e_phase != PH_DONE);
        if (in_number) begin
          if (data_byte_i == CHAR_SPACE) begin
            if (e_phase == PH_BEFORE) bad_d = 1'b1;
            phase_d = PH_DONE;
          end else if (is_digit) begin
            acc_d   = (acc_x10 > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : acc_x10[ACC_W-1:0];
            phase_d = PH_DIGITS;
          end else begin
            bad_d = 1'b1;
          end
        end
        recent_d = {e_recent[15:0], data_byte_i};
        cnt_d    = e_cnt + CNT_W'(1);

        if (hdr_end) begin
          res_fire = 1'b1;
          done_d   = 1'b1;
          offset_d = BODY_W'(cnt_d);
          // First alive prefix in list order wins
          if (alive_d[OUT_STATUS]) begin
            outcome_d = OUT_STATUS;
          end else if (alive_d[OUT_CONFIGURE]) begin
            outcome_d = OUT_CONFIGURE;
          end else if (alive_d[OUT_RANK] || alive_d[OUT_SIZE]) begin
            // The closing LF is no digit, so the count is the one from before this byte
            if (bad_d || (phase_d != PH_DONE) || (e_acc >= {1'b0, limit_q})) begin
              outcome_d = OUT_BAD;
            end else begin
              outcome_d = alive_d[OUT_RANK] ? OUT_RANK : OUT_SIZE;
              number_d  = e_acc[NUM_W-1:0];
            end
          end else if (alive_d[OUT_ROUTING]) begin
            outcome_d = OUT_ROUTING;
          end else begin
            outcome_d = OUT_NOT_FOUND;
          end
        end else if (end_of_data_i || (cnt_d >= CNT_MAX)) begin
          // no header end in time: bad request, no body offset
          res_fire = 1'b1;
          done_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      alive_q     <= '1;
      cnt_q       <= '0;
      recent_q    <= '0;
      acc_q       <= '0;
      phase_q     <= PH_BEFORE;
      bad_q       <= 1'b0;
      done_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        alive_q  <= alive_d;
        cnt_q    <= cnt_d;
        recent_q <= recent_d;
        acc_q    <= acc_d;
        phase_q  <= phase_d;
        bad_q    <= bad_d;
        done_q   <= done_d;
      end
      if (accept && res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (accept && res_fire) begin
      outcome_q <= outcome_d;
      number_q  <= number_d;
      offset_q  <= offset_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = outcome_q;
  assign number_value_o = number_q;
  assign body_offset_o  = offset_q;

  `HRC_ASSERT(a_num_only_rank_size, clk_i, rst_ni, (out_valid_o && (number_value_o != '0)) |-> ((outcome_o == OUT_RANK) || (outcome_o == OUT_SIZE)), "number reported on a non-number outcome")
  `HRC_ASSERT(a_num_below_limit, clk_i, rst_ni, (out_valid_o && ((outcome_o == OUT_RANK) || (outcome_o == OUT_SIZE))) |-> (number_value_o < limit_q), "accepted number not below cluster limit")
  `HRC_ASSERT(a_done_after_result, clk_i, rst_ni, (accept && res_fire) |=> done_q, "request not closed after its result")
  `HRC_ASSERT_ALWAYS(a_count_bounded, clk_i, !rst_ni || (cnt_q <= CNT_MAX), "byte count beyond header limit")

endmodule

>>> bench/http_request_classifier_core_tb.sv
// Self-checking bench for the HTTP request classifier core: byte stream in, one verdict out.
`timescale 1ns / 100ps

module http_request_classifier_core_tb
  import hrc_pkg::*;
();

  localparam int HDR_MAX      = MAX_HEADER_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_WORDS  = 1550;
  localparam int PHASES       = 6;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              eod;
  } req_word_t;

  typedef struct packed {
    outcome_e          outcome;
    logic [NUM_W-1:0]  num;
    logic [BODY_W-1:0] offset;
  } verdict_t;

  // DUT connections; every input has a known value from time zero
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata   = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  data_byte   = '0;
  logic               first_byte  = 1'b0;
  logic               end_of_data = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [OUTC_W-1:0]  outcome;
  logic [NUM_W-1:0]   number_value;
  logic [BODY_W-1:0]  body_offset;

  // bench bookkeeping
  req_word_t   byte_backlog [$];
  verdict_t    verdicts_due [$];
  logic [BYTE_W-1:0] req_bytes [$];
  int          counted_words  = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          feed_gap       = 0;
  int          feed_quiet     = 0;
  int          drain_stall    = 0;
  int          drain_quiet    = 0;
  req_word_t   drv_word;
  verdict_t    drv_verdict;
  verdict_t    mon_want;

  // classifier shadow state
  string       prefix_txt  [NUM_PREFIXES] = '{"GET /status", "POST /configure", "PUT /rank/",
                                              "PUT /size/", "POST /routing"};
  outcome_e    prefix_code [NUM_PREFIXES] = '{OUT_STATUS, OUT_CONFIGURE, OUT_RANK,
                                              OUT_SIZE, OUT_ROUTING};
  logic [NUM_PREFIXES-1:0] live_prefixes  = '1;
  logic [BODY_W-1:0]       seen_count     = '0;
  logic [23:0]             last_three     = '0;
  logic [ACC_W-1:0]        number_acc     = '0;
  num_phase_e              number_state   = PH_BEFORE;
  logic                    number_broken  = 1'b0;
  logic                    awaiting_first = 1'b1;
  int                      limit_model    = int'(LIMIT_RESET);

  http_request_classifier_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .first_byte_i   (first_byte),
    .end_of_data_i  (end_of_data),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .outcome_o      (outcome),
    .number_value_o (number_value),
    .body_offset_o  (body_offset)
  );

  always #6 clk = ~clk;

  // Advance the shadow classifier by one accepted byte; return 1 when a verdict is due.
  function automatic bit classify_byte(input logic [BYTE_W-1:0] b, input logic first,
                                       input logic eod, output verdict_t v);
    int pos;
    int acc;
    bit on_number_path;
    bit hdr_end;
    v = '{outcome: OUT_BAD, num: '0, offset: '0};
    if (first) begin
      live_prefixes  = '1;
      seen_count     = '0;
      last_three     = '0;
      number_acc     = '0;
      number_state   = PH_BEFORE;
      number_broken  = 1'b0;
      awaiting_first = 1'b0;
    end
    if (awaiting_first) return 1'b0;
    // NUL ends the text at once, with no body offset
    if (b == CHAR_NUL) begin
      awaiting_first = 1'b1;
      return 1'b1;
    end
    pos = int'(seen_count);
    for (int i = 0; i < NUM_PREFIXES; i++)
      if (pos < prefix_txt[i].len() && prefix_txt[i][pos] != b) live_prefixes[i] = 1'b0;
    on_number_path = 1'b0;
    for (int i = 0; i < NUM_PREFIXES; i++)
      if (live_prefixes[i] && (prefix_code[i] == OUT_RANK || prefix_code[i] == OUT_SIZE))
        on_number_path = 1'b1;
    if (pos >= NUMBER_START && on_number_path && number_state != PH_DONE) begin
      if (b == CHAR_SPACE) begin
        if (number_state == PH_BEFORE) number_broken = 1'b1;
        number_state = PH_DONE;
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        acc = int'(number_acc) * 10 + int'(b - CHAR_ZERO);
        if (acc > int'(ACC_MAX)) acc = int'(ACC_MAX);
        number_acc   = acc[ACC_W-1:0];
        number_state = PH_DIGITS;
      end else begin
        number_broken = 1'b1;
      end
    end
    hdr_end    = (last_three == CRLFCR) && (b == CHAR_LF);
    last_three = {last_three[15:0], b};
    seen_count = seen_count + 1'b1;
    if (hdr_end) begin
      awaiting_first = 1'b1;
      v.offset  = seen_count;
      v.outcome = OUT_NOT_FOUND;
      // first fully matched prefix in table order wins
      for (int i = 0; i < NUM_PREFIXES; i++) begin
        if (live_prefixes[i]) begin
          if (prefix_code[i] == OUT_RANK || prefix_code[i] == OUT_SIZE) begin
            if (number_broken || number_state != PH_DONE || int'(number_acc) >= limit_model) begin
              v.outcome = OUT_BAD;
            end else begin
              v.outcome = prefix_code[i];
              v.num     = number_acc[NUM_W-1:0];
            end
          end else begin
            v.outcome = prefix_code[i];
          end
          return 1'b1;
        end
      end
      return 1'b1;
    end
    if (eod || seen_count >= HDR_MAX) begin
      awaiting_first = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Idle length for one word: mostly 0..7, with occasional runs of back-to-back words.
  function automatic int draw_idle(inout int quiet_run);
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      quiet_run = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // Request builders: collect bytes in req_bytes, then hand them to the driver.
  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    req_bytes.push_back(b);
  endfunction

  function automatic void add_str(input string s);
    for (int k = 0; k < s.len(); k++) req_bytes.push_back(s[k]);
  endfunction

  function automatic void add_token(input int n);
    repeat (n) req_bytes.push_back(BYTE_W'($urandom_range(33, 126)));
  endfunction

  function automatic void add_eoh();
    add_byte(CHAR_CR);
    add_byte(CHAR_LF);
    add_byte(CHAR_CR);
    add_byte(CHAR_LF);
  endfunction

  // Every word handed to the driver counts toward the word budget.
  function automatic void push_word(input logic [BYTE_W-1:0] b, input logic first,
                                    input logic eod);
    byte_backlog.push_back('{data: b, first: first, eod: eod});
    counted_words++;
  endfunction

  // Queue the collected request (first on its first byte), then trailing body bytes
  // that the block drops.
  function automatic void emit_request(input bit eod_last, input int body_len);
    for (int k = 0; k < req_bytes.size(); k++)
      push_word(req_bytes[k], 1'(k == 0), 1'(eod_last && k == req_bytes.size() - 1));
    req_bytes.delete();
    repeat (body_len)
      push_word(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endfunction

  // Decimal field after the rank or size prefix, valid or not.
  function automatic void add_number();
    int v;
    v = -1;
    case ($urandom_range(0, 8))
      0, 1, 2, 3: v = $urandom_range(0, limit_model - 1);
      4:          v = limit_model + $urandom_range(0, 2);
      5: begin
        add_str("00");
        v = $urandom_range(0, 9);
      end
      6:       repeat ($urandom_range(6, 9)) add_byte(BYTE_W'(CHAR_ZERO + $urandom_range(0, 9)));
      7:       v = -1;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v >= 0) add_str($sformatf("%0d", v));
    case ($urandom_range(0, 9))
      0: begin
        add_byte(BYTE_W'(8'h61 + $urandom_range(0, 25)));
        add_str(" HTTP/1.1");
      end
      1:       ;  // no space: header end arrives inside the number
      default: add_str(" HTTP/1.1");
    endcase
  endfunction

  function automatic void gen_well_formed();
    int    k;
    int    pos;
    string s;
    k = $urandom_range(0, NUM_PREFIXES);
    if (k == NUM_PREFIXES) begin
      // near miss: drop the last prefix character or damage one
      s = prefix_txt[$urandom_range(0, NUM_PREFIXES - 1)];
      if ($urandom_range(0, 1)) begin
        s = s.substr(0, s.len() - 2);
      end else begin
        pos = $urandom_range(0, s.len() - 1);
        s.putc(pos, byte'($urandom_range(33, 126)));
      end
      add_str(s);
      add_str(" HTTP/1.1");
    end else begin
      add_str(prefix_txt[k]);
      if (prefix_code[k] == OUT_RANK || prefix_code[k] == OUT_SIZE) begin
        add_number();
      end else begin
        if ($urandom_range(0, 3) == 0) add_token($urandom_range(1, 4));
        add_str(" HTTP/1.1");
      end
    end
    repeat ($urandom_range(0, 3)) begin
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
      add_token($urandom_range(1, 16));
    end
    add_eoh();
    emit_request($urandom_range(0, 3) == 0, $urandom_range(0, 6));
  endfunction

  function automatic void gen_broken();
    string s;
    s = prefix_txt[$urandom_range(0, NUM_PREFIXES - 1)];
    case ($urandom_range(0, 5))
      0: begin
        repeat ($urandom_range(1, 24)) add_byte(BYTE_W'($urandom_range(0, 255)));
        emit_request(1'($urandom_range(0, 1)), 0);
      end
      1: begin
        add_str(s.substr(0, $urandom_range(0, s.len() - 1)));
        emit_request(1'b1, 0);
      end
      2: begin
        add_str(s.substr(0, $urandom_range(0, s.len() - 1)));
        add_byte(CHAR_NUL);
        add_token($urandom_range(0, 4));
        emit_request(1'b0, 0);
      end
      3: begin
        // abandoned mid-line; the next first byte restarts the parse
        add_str(s.substr(0, $urandom_range(0, s.len() - 1)));
        add_token($urandom_range(0, 6));
        emit_request(1'b0, 0);
      end
      4: begin
        add_str(s);
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
        add_byte(CHAR_CR);
        add_token(1);
        add_byte(CHAR_LF);
        add_eoh();
        emit_request(1'b0, $urandom_range(0, 3));
      end
      default: begin
        add_eoh();
        emit_request(1'b0, 0);
      end
    endcase
  endfunction

  // Wait until every queued byte is taken and every verdict has drained, then settle.
  // Check at the falling edge so the driver's decisions of the last rising edge are in.
  task automatic drain();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_model = int'(v);
  endtask

  // Byte driver: predict on each accepted word, then present the next one after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (classify_byte(data_byte, first_byte, end_of_data, drv_verdict))
          verdicts_due.push_back(drv_verdict);
      end
      if (!in_valid || in_ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          drv_word    = byte_backlog.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= drv_word.data;
          first_byte  <= drv_word.first;
          end_of_data <= drv_word.eod;
          feed_gap    = draw_idle(feed_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken word with the oldest prediction, then stall a while.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual outcome %0d", $time,
                   outcome);
          mismatch_count++;
        end else begin
          mon_want = verdicts_due.pop_front();
          if (outcome !== mon_want.outcome) begin
            $display("%0t: outcome: expected %0d, actual %0d", $time, mon_want.outcome,
                     outcome);
            mismatch_count++;
          end
          if (number_value !== mon_want.num) begin
            $display("%0t: number_value: expected %0d, actual %0d", $time, mon_want.num,
                     number_value);
            mismatch_count++;
          end
          if (body_offset !== mon_want.offset) begin
            $display("%0t: body_offset: expected %0d, actual %0d", $time, mon_want.offset,
                     body_offset);
            mismatch_count++;
          end
        end
        drain_stall = draw_idle(drain_quiet);
      end
      if (drain_stall > 0) begin
        drain_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int phase_limit [PHASES];
    int target;
    phase_limit = '{64, 1, 65535, 1000, 0, 9};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed requests at the reset limit of 64
    push_word(8'hAB, 1'b0, 1'b0);    // idle, dropped
    push_word(CHAR_NUL, 1'b0, 1'b1); // idle NUL, dropped
    add_str("GET /status");             add_eoh(); emit_request(1'b0, 2);
    add_str("POST /configure HTTP/1.1"); add_eoh(); emit_request(1'b0, 0);
    add_str("PUT /rank/5 HTTP/1.1");    add_eoh(); emit_request(1'b0, 0);
    add_str("PUT /size/63 x");          add_eoh(); emit_request(1'b0, 0);
    add_str("PUT /rank/64 ");           add_eoh(); emit_request(1'b0, 0);  // at the limit
    add_str("PUT /rank/ ");             add_eoh(); emit_request(1'b0, 0);  // no digits
    add_str("PUT /size/1a ");           add_eoh(); emit_request(1'b0, 0);  // non-digit
    add_str("PUT /size/12");            add_eoh(); emit_request(1'b0, 0);  // no space
    add_str("POST /routing");           add_eoh(); emit_request(1'b1, 0);  // eod on last LF
    add_str("GET /statu HTTP/1.1");     add_eoh(); emit_request(1'b0, 0);  // last char off
    add_str("GET /x");                  add_eoh(); emit_request(1'b0, 0);
    push_word(CHAR_NUL, 1'b1, 1'b0);                                      // NUL as first byte
    add_str("GET /st");                 emit_request(1'b1, 0);             // eod, no header end
    add_str("GET /sta");                emit_request(1'b0, 0);             // restarted below
    add_str("GET /");                   add_token(HDR_MAX); emit_request(1'b0, 0);  // too long
    push_word(8'hFF, 1'b0, 1'b0);

    // random requests over several limits, extremes included
    for (int p = 0; p < PHASES; p++) begin
      set_limit(LIMIT_W'(phase_limit[p] != 0 ? phase_limit[p] : $urandom_range(2, 65534)));
      // split what is left of the word budget over the phases still to run
      target = counted_words + (TOTAL_WORDS - counted_words) / (PHASES - p);
      while (counted_words < target) begin
        if ($urandom_range(0, 99) < 75) gen_well_formed();
        else gen_broken();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, verdicts_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
